/* design/json_event_tokenizer_core_defines.svh */
// assertion macros for the json event tokenizer checker
// expects clk_i and rst_ni in the scope of each use
`ifndef JSON_EVENT_TOKENIZER_CORE_DEFINES_SVH
`define JSON_EVENT_TOKENIZER_CORE_DEFINES_SVH

// generic clocked property check
`define JET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// a stalled valid must stay up until its transfer
`define JET_ASSERT_HOLD(lbl, vld, rdy, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (vld && !rdy) |=> vld) \
    else $error(msg);

`endif

/* design/jet_pkg.sv */
// shared types, codes and character helpers for the json event tokenizer
// no dependencies
package jet_pkg;

  localparam int MaxEvents = 4;
  localparam int PosW      = 20;
  localparam int AmtW      = 21;

  typedef enum logic [3:0] {
    EV_DOC  = 4'd0,
    EV_OBJ  = 4'd1,
    EV_ARR  = 4'd2,
    EV_KEY  = 4'd3,
    EV_IDX  = 4'd4,
    EV_STR  = 4'd5,
    EV_BOOL = 4'd6,
    EV_NULL = 4'd7,
    EV_NUM  = 4'd8,
    EV_ERR  = 4'd9
  } ev_kind_e;

  typedef enum logic [2:0] {
    ERR_MISSING_KEY   = 3'd0,
    ERR_UNTERM_KEY    = 3'd1,
    ERR_MISSING_VALUE = 3'd2,
    ERR_UNTERM_OBJ    = 3'd3,
    ERR_UNTERM_ARR    = 3'd4,
    ERR_UNTERM_STR    = 3'd5,
    ERR_INVALID_VALUE = 3'd6
  } err_code_e;

  typedef enum logic [17:0] {
    PH_VALUE       = 18'h00001,
    PH_ARR_ELEM    = 18'h00002,
    PH_ARR_NEXT    = 18'h00004,
    PH_OBJ_KEY     = 18'h00008,
    PH_KEY_TEXT    = 18'h00010,
    PH_OBJ_COLON   = 18'h00020,
    PH_OBJ_NEXT    = 18'h00040,
    PH_STR_TEXT    = 18'h00080,
    PH_TRUE        = 18'h00100,
    PH_FALSE       = 18'h00200,
    PH_NULL        = 18'h00400,
    PH_NUM_SIGN    = 18'h00800,
    PH_NUM_INT     = 18'h01000,
    PH_NUM_FRAC0   = 18'h02000,
    PH_NUM_FRAC    = 18'h04000,
    PH_NUM_EXP0    = 18'h08000,
    PH_NUM_EXPSIGN = 18'h10000,
    PH_NUM_EXP     = 18'h20000
  } phase_e;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLbrace = 8'h7b;
  localparam logic [7:0] ChRbrace = 8'h7d;
  localparam logic [7:0] ChLbrack = 8'h5b;
  localparam logic [7:0] ChRbrack = 8'h5d;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6e;

  typedef struct packed {
    ev_kind_e        kind;
    logic [PosW-1:0] pos;
    logic [AmtW-1:0] amount;
    logic [2:0]      code;
  } ev_t;

  typedef struct packed {
    ev_t [MaxEvents-1:0] ev;
    logic [2:0]          num;
  } grp_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // expected letter of true, false or null at a given match count
  function automatic logic [7:0] lit_char(phase_e ph, logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    unique case (ph)
      PH_TRUE: begin
        unique case (i)
          3'd0:    r = "t";
          3'd1:    r = "r";
          3'd2:    r = "u";
          default: r = "e";
        endcase
      end
      PH_FALSE: begin
        unique case (i)
          3'd0:    r = "f";
          3'd1:    r = "a";
          3'd2:    r = "l";
          3'd3:    r = "s";
          default: r = "e";
        endcase
      end
      default: begin
        unique case (i)
          3'd0:    r = "n";
          3'd1:    r = "u";
          default: r = "l";
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(phase_e ph);
    return (ph == PH_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

/* design/jet_if.sv */
// valid/ready channel interfaces for text bytes in and events out
// depends on nothing
interface jet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface jet_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [19:0] position;
  logic [20:0] amount;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, event_kind, position, amount, error_code, last_of_run,
                  input ready);
  modport sink (input valid, event_kind, position, amount, error_code, last_of_run,
                output ready);
endinterface

/* design/jet_parse.sv */
// parser state registers and the per-byte event logic
// depends on jet_pkg
module jet_parse #(
  parameter int NEST_DEPTH  = 32,
  parameter int OFFSET_BITS = 20,
  localparam int LvlW       = $clog2(NEST_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_byte_i,
  input  logic                   last_byte_i,
  input  logic                   below_kind_i,
  input  logic [OFFSET_BITS-1:0] below_cnt_i,
  output jet_pkg::grp_t          grp_o,
  output logic                   wr_en_o,
  output logic [LvlW-1:0]        wr_lvl_o,
  output logic                   wr_kind_o,
  output logic [OFFSET_BITS-1:0] wr_cnt_o,
  output logic [LvlW-1:0]        rd_lvl_o
);

  typedef logic [OFFSET_BITS-1:0] off_t;

  typedef struct packed {
    jet_pkg::phase_e phase;
    logic [LvlW-1:0] level;
    logic            top_kind;
    off_t            top_cnt;
    off_t            tstart;
    logic            bs;
    logic [2:0]      lit;
    logic            done;
  } st_t;

  typedef struct packed {
    st_t                                 st;
    jet_pkg::ev_t [jet_pkg::MaxEvents-1:0] ev;
    logic [2:0]                          num;
    logic                                again;
    logic                                push;
    logic                                push_kind;
    off_t                                push_cnt;
  } wk_t;

  st_t             st_q;
  off_t            off_q;
  off_t            off_cur;
  wk_t             w;
  logic [LvlW-1:0] lvl0;

  function automatic wk_t f_emit(wk_t w_in, jet_pkg::ev_kind_e k, off_t pos, off_t amt,
                                 logic [2:0] code);
    wk_t r;
    r = w_in;
    if (r.num < 3'd4) begin
      r.ev[r.num[1:0]].kind   = k;
      r.ev[r.num[1:0]].pos    = jet_pkg::PosW'(pos);
      r.ev[r.num[1:0]].amount = jet_pkg::AmtW'(amt);
      r.ev[r.num[1:0]].code   = code;
      r.num = r.num + 3'd1;
    end
    return r;
  endfunction

  function automatic wk_t f_fail(wk_t w_in, off_t o, jet_pkg::err_code_e code);
    wk_t r;
    r = f_emit(w_in, jet_pkg::EV_ERR, o, '0, code);
    r.st.done = 1'b1;
    return r;
  endfunction

  function automatic wk_t f_complete(wk_t w_in);
    wk_t r;
    r = w_in;
    if (r.st.level == '0) begin
      r = f_emit(r, jet_pkg::EV_DOC, '0, '0, '0);
      r.st.done = 1'b1;
    end else if (r.st.top_kind) begin
      r.st.phase = jet_pkg::PH_ARR_NEXT;
    end else begin
      r.st.phase = jet_pkg::PH_OBJ_NEXT;
    end
    return r;
  endfunction

  function automatic wk_t f_close(wk_t w_in, off_t o, logic bk, off_t bc);
    wk_t  r;
    logic is_arr;
    r = w_in;
    is_arr = r.st.top_kind;
    r.st.level = r.st.level - LvlW'(1);
    r.st.top_kind = bk;
    r.st.top_cnt = bc;
    if (is_arr) begin
      r = f_emit(r, jet_pkg::EV_ARR, o, '0, '0);
    end else begin
      r = f_emit(r, jet_pkg::EV_OBJ, o, '0, '0);
    end
    return f_complete(r);
  endfunction

  function automatic wk_t f_open(wk_t w_in, off_t o, logic is_arr);
    wk_t r;
    r = w_in;
    if (32'(r.st.level) >= NEST_DEPTH) begin
      r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
    end else begin
      r.push = 1'b1;
      r.push_kind = r.st.top_kind;
      r.push_cnt = r.st.top_cnt;
      r.st.top_kind = is_arr;
      r.st.top_cnt = '0;
      r.st.level = r.st.level + LvlW'(1);
      if (is_arr) begin
        r = f_emit(r, jet_pkg::EV_ARR, o, off_t'(1), '0);
        r.st.phase = jet_pkg::PH_ARR_ELEM;
      end else begin
        r = f_emit(r, jet_pkg::EV_OBJ, o, off_t'(1), '0);
        r.st.phase = jet_pkg::PH_OBJ_KEY;
      end
    end
    return r;
  endfunction

  function automatic wk_t f_start(wk_t w_in, logic [7:0] c, off_t o);
    wk_t r;
    r = w_in;
    priority if (c == jet_pkg::ChLbrace) begin
      r = f_open(r, o, 1'b0);
    end else if (c == jet_pkg::ChLbrack) begin
      r = f_open(r, o, 1'b1);
    end else if (c == jet_pkg::ChQuote) begin
      r.st.tstart = o + off_t'(1);
      r.st.bs = 1'b0;
      r.st.phase = jet_pkg::PH_STR_TEXT;
    end else if (c == jet_pkg::ChLowT) begin
      r.st.lit = 3'd1;
      r.st.phase = jet_pkg::PH_TRUE;
    end else if (c == jet_pkg::ChLowF) begin
      r.st.lit = 3'd1;
      r.st.phase = jet_pkg::PH_FALSE;
    end else if (c == jet_pkg::ChLowN) begin
      r.st.lit = 3'd1;
      r.st.phase = jet_pkg::PH_NULL;
    end else if (c == jet_pkg::ChMinus) begin
      r.st.tstart = o;
      r.st.phase = jet_pkg::PH_NUM_SIGN;
    end else if (jet_pkg::is_digit(c)) begin
      r.st.tstart = o;
      r.st.phase = jet_pkg::PH_NUM_INT;
    end else begin
      r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
    end
    return r;
  endfunction

  // one pass of the byte through the phase logic
  function automatic wk_t f_pass(wk_t w_in, logic [7:0] c, off_t o, logic bk, off_t bc);
    wk_t  r;
    logic sp;
    logic dg;
    r = w_in;
    r.again = 1'b0;
    sp = jet_pkg::is_space(c);
    dg = jet_pkg::is_digit(c);
    unique case (r.st.phase)
      jet_pkg::PH_VALUE: begin
        if (!sp) r = f_start(r, c, o);
      end
      jet_pkg::PH_ARR_ELEM: begin
        if (c == jet_pkg::ChRbrack) begin
          r = f_close(r, o, bk, bc);
        end else if (!sp) begin
          r = f_emit(r, jet_pkg::EV_IDX, o, r.st.top_cnt, '0);
          r.st.top_cnt = r.st.top_cnt + off_t'(1);
          r = f_start(r, c, o);
        end
      end
      jet_pkg::PH_ARR_NEXT: begin
        if (c == jet_pkg::ChComma) begin
          r.st.phase = jet_pkg::PH_ARR_ELEM;
        end else if (c == jet_pkg::ChRbrack) begin
          r = f_close(r, o, bk, bc);
        end else if (!sp) begin
          r = f_fail(r, o, jet_pkg::ERR_UNTERM_ARR);
        end
      end
      jet_pkg::PH_OBJ_KEY: begin
        if (c == jet_pkg::ChRbrace) begin
          r = f_close(r, o, bk, bc);
        end else if (c == jet_pkg::ChQuote) begin
          r.st.tstart = o + off_t'(1);
          r.st.bs = 1'b0;
          r.st.phase = jet_pkg::PH_KEY_TEXT;
        end else if (!sp) begin
          r = f_fail(r, o, jet_pkg::ERR_MISSING_KEY);
        end
      end
      jet_pkg::PH_KEY_TEXT: begin
        if (c == jet_pkg::ChNul) begin
          r = f_fail(r, o, jet_pkg::ERR_UNTERM_KEY);
        end else if (c == jet_pkg::ChQuote && !r.st.bs) begin
          r = f_emit(r, jet_pkg::EV_KEY, r.st.tstart, o - r.st.tstart, '0);
          r.st.phase = jet_pkg::PH_OBJ_COLON;
        end else begin
          r.st.bs = (c == jet_pkg::ChBslash);
        end
      end
      jet_pkg::PH_OBJ_COLON: begin
        if (c == jet_pkg::ChColon) begin
          r.st.phase = jet_pkg::PH_VALUE;
        end else if (!sp) begin
          r = f_fail(r, o, jet_pkg::ERR_MISSING_VALUE);
        end
      end
      jet_pkg::PH_OBJ_NEXT: begin
        if (c == jet_pkg::ChComma) begin
          r.st.phase = jet_pkg::PH_OBJ_KEY;
        end else if (c == jet_pkg::ChRbrace) begin
          r = f_close(r, o, bk, bc);
        end else if (!sp) begin
          r = f_fail(r, o, jet_pkg::ERR_UNTERM_OBJ);
        end
      end
      jet_pkg::PH_STR_TEXT: begin
        if (c == jet_pkg::ChNul) begin
          r = f_fail(r, o, jet_pkg::ERR_UNTERM_STR);
        end else if (c == jet_pkg::ChQuote && !r.st.bs) begin
          r = f_emit(r, jet_pkg::EV_STR, r.st.tstart, o - r.st.tstart, '0);
          r = f_complete(r);
        end else begin
          r.st.bs = (c == jet_pkg::ChBslash);
        end
      end
      jet_pkg::PH_TRUE, jet_pkg::PH_FALSE, jet_pkg::PH_NULL: begin
        if (r.st.lit < jet_pkg::lit_len(r.st.phase) &&
            c == jet_pkg::lit_char(r.st.phase, r.st.lit)) begin
          r.st.lit = r.st.lit + 3'd1;
          if (r.st.lit == jet_pkg::lit_len(r.st.phase)) begin
            r.st.lit = 3'd0;
            if (r.st.phase == jet_pkg::PH_TRUE) begin
              r = f_emit(r, jet_pkg::EV_BOOL, '0, off_t'(1), '0);
            end else if (r.st.phase == jet_pkg::PH_FALSE) begin
              r = f_emit(r, jet_pkg::EV_BOOL, '0, '0, '0);
            end else begin
              r = f_emit(r, jet_pkg::EV_NULL, '0, '0, '0);
            end
            r = f_complete(r);
          end
        end else begin
          r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
        end
      end
      jet_pkg::PH_NUM_SIGN: begin
        if (dg) r.st.phase = jet_pkg::PH_NUM_INT;
        else    r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
      end
      jet_pkg::PH_NUM_FRAC0: begin
        if (dg) r.st.phase = jet_pkg::PH_NUM_FRAC;
        else    r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
      end
      jet_pkg::PH_NUM_EXPSIGN: begin
        if (dg) r.st.phase = jet_pkg::PH_NUM_EXP;
        else    r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
      end
      jet_pkg::PH_NUM_EXP0: begin
        if (c == jet_pkg::ChPlus || c == jet_pkg::ChMinus) begin
          r.st.phase = jet_pkg::PH_NUM_EXPSIGN;
        end else if (dg) begin
          r.st.phase = jet_pkg::PH_NUM_EXP;
        end else begin
          r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
        end
      end
      jet_pkg::PH_NUM_INT, jet_pkg::PH_NUM_FRAC, jet_pkg::PH_NUM_EXP: begin
        if (dg) begin
          r.st.phase = r.st.phase;
        end else if (c == jet_pkg::ChDot && r.st.phase == jet_pkg::PH_NUM_INT) begin
          r.st.phase = jet_pkg::PH_NUM_FRAC0;
        end else if ((c == jet_pkg::ChLowE || c == jet_pkg::ChUpE) &&
                     r.st.phase != jet_pkg::PH_NUM_EXP) begin
          r.st.phase = jet_pkg::PH_NUM_EXP0;
        end else begin
          // number ends, byte is parsed again as what follows the value
          r = f_emit(r, jet_pkg::EV_NUM, r.st.tstart, o - r.st.tstart, '0);
          r = f_complete(r);
          r.again = !r.st.done;
        end
      end
      default: begin
        r = f_fail(r, o, jet_pkg::ERR_INVALID_VALUE);
      end
    endcase
    return r;
  endfunction

  assign off_cur = first_byte_i ? '0 : off_q;

  always_comb begin
    w = '0;
    w.st = st_q;
    if (first_byte_i) begin
      w.st.phase  = jet_pkg::PH_VALUE;
      w.st.level  = '0;
      w.st.tstart = '0;
      w.st.bs     = 1'b0;
      w.st.lit    = 3'd0;
      w.st.done   = 1'b0;
      w = f_emit(w, jet_pkg::EV_DOC, '0, off_t'(1), '0);
    end
    lvl0 = w.st.level;
    if (!w.st.done) begin
      w = f_pass(w, data_byte_i, off_cur, below_kind_i, below_cnt_i);
      if (w.again) w = f_pass(w, data_byte_i, off_cur, below_kind_i, below_cnt_i);
    end
    // virtual terminator after the last byte
    if (last_byte_i && !w.st.done && data_byte_i != jet_pkg::ChNul) begin
      w = f_pass(w, jet_pkg::ChNul, off_cur + off_t'(1), below_kind_i, below_cnt_i);
      if (w.again) begin
        w = f_pass(w, jet_pkg::ChNul, off_cur + off_t'(1), below_kind_i, below_cnt_i);
      end
    end
  end

  assign grp_o.ev  = w.ev;
  assign grp_o.num = w.num;
  assign wr_en_o   = w.push && (lvl0 != '0);
  assign wr_lvl_o  = lvl0 - LvlW'(1);
  assign wr_kind_o = w.push_kind;
  assign wr_cnt_o  = w.push_cnt;
  assign rd_lvl_o  = accept_i ? w.st.level : st_q.level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{phase: jet_pkg::PH_VALUE, default: '0};
      off_q <= '0;
    end else if (accept_i) begin
      st_q  <= w.st;
      off_q <= off_cur + off_t'(1);
    end
  end

endmodule

/* design/jet_stack.sv */
// nesting stack memory for the levels below the cached top entry
// registered read with write bypass, depends on nothing
module jet_stack #(
  parameter int NEST_DEPTH  = 32,
  parameter int OFFSET_BITS = 20,
  localparam int LvlW       = $clog2(NEST_DEPTH + 1),
  localparam int IdxW       = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [LvlW-1:0]        wr_lvl_i,
  input  logic                   wr_kind_i,
  input  logic [OFFSET_BITS-1:0] wr_cnt_i,
  input  logic [LvlW-1:0]        rd_lvl_i,
  output logic                   rd_kind_o,
  output logic [OFFSET_BITS-1:0] rd_cnt_o
);

  logic                   kind_mem [NEST_DEPTH];
  logic [OFFSET_BITS-1:0] cnt_mem  [NEST_DEPTH];
  logic [IdxW-1:0]        wr_idx;
  logic [IdxW-1:0]        rd_idx;
  logic [LvlW-1:0]        rd_m2;

  // entry under the top after the next pop
  assign rd_m2  = rd_lvl_i - LvlW'(1) - LvlW'(1);
  assign rd_idx = (32'(rd_lvl_i) >= 2) ? IdxW'(rd_m2) : '0;
  assign wr_idx = IdxW'(wr_lvl_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      kind_mem[wr_idx] <= wr_kind_i;
      cnt_mem[wr_idx]  <= wr_cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx == rd_idx) begin
      rd_kind_o <= wr_kind_i;
      rd_cnt_o  <= wr_cnt_i;
    end else begin
      rd_kind_o <= kind_mem[rd_idx];
      rd_cnt_o  <= cnt_mem[rd_idx];
    end
  end

endmodule

/* design/jet_evq.sv */
// two-entry queue of per-byte event groups, drained one event per transfer
// depends on jet_pkg and jet_out_if
module jet_evq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jet_pkg::grp_t grp_i,
  output logic          space_o,
  jet_out_if.source     evt_o
);

  jet_pkg::grp_t grp_q [2];
  jet_pkg::grp_t cur;
  jet_pkg::ev_t  ev;
  logic          head_q;
  logic          tail_q;
  logic [1:0]    cnt_q;
  logic [1:0]    rd_q;
  logic          last;
  logic          xfer;
  logic          pop;

  assign cur  = grp_q[head_q];
  assign ev   = cur.ev[rd_q];
  assign last = ({1'b0, rd_q} + 3'd1) == cur.num;
  assign xfer = evt_o.valid && evt_o.ready;
  assign pop  = xfer && last;

  assign space_o           = cnt_q != 2'd2;
  assign evt_o.valid       = cnt_q != 2'd0;
  assign evt_o.event_kind  = ev.kind;
  assign evt_o.position    = ev.pos;
  assign evt_o.amount      = ev.amount;
  assign evt_o.error_code  = ev.code;
  assign evt_o.last_of_run = last;

  always_ff @(posedge clk_i) begin
    if (push_i) grp_q[tail_q] <= grp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      tail_q <= 1'b0;
      cnt_q  <= 2'd0;
      rd_q   <= 2'd0;
    end else begin
      if (push_i) tail_q <= ~tail_q;
      if (pop) head_q <= ~head_q;
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
      if (xfer) rd_q <= last ? 2'd0 : rd_q + 2'd1;
    end
  end

endmodule

/* design/json_event_tokenizer_core.sv */
// json event tokenizer: one text byte in, zero to four events out per byte
// a byte's events are written into the event queue as the byte transfers
// throughput: one byte per cycle while the event queue has space; the event
// port moves one event per cycle while ready is high
// reset: asynchronous, parser waits for a top-level value, offset zero,
// the stack memory is not cleared
module json_event_tokenizer_core #(
  parameter int NEST_DEPTH  = 32,
  parameter int OFFSET_BITS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jet_in_if.sink    byte_i,
  jet_out_if.source evt_o
);

  localparam int LvlW = $clog2(NEST_DEPTH + 1);

  logic                   accept;
  logic                   space;
  jet_pkg::grp_t          grp;
  logic                   wr_en;
  logic [LvlW-1:0]        wr_lvl;
  logic                   wr_kind;
  logic [OFFSET_BITS-1:0] wr_cnt;
  logic [LvlW-1:0]        rd_lvl;
  logic                   below_kind;
  logic [OFFSET_BITS-1:0] below_cnt;

  assign byte_i.ready = space;
  assign accept       = byte_i.valid && space;

  jet_parse #(
    .NEST_DEPTH  (NEST_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (byte_i.data_byte),
    .first_byte_i (byte_i.first_byte),
    .last_byte_i  (byte_i.last_byte),
    .below_kind_i (below_kind),
    .below_cnt_i  (below_cnt),
    .grp_o        (grp),
    .wr_en_o      (wr_en),
    .wr_lvl_o     (wr_lvl),
    .wr_kind_o    (wr_kind),
    .wr_cnt_o     (wr_cnt),
    .rd_lvl_o     (rd_lvl)
  );

  jet_stack #(
    .NEST_DEPTH  (NEST_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (accept && wr_en),
    .wr_lvl_i  (wr_lvl),
    .wr_kind_i (wr_kind),
    .wr_cnt_i  (wr_cnt),
    .rd_lvl_i  (rd_lvl),
    .rd_kind_o (below_kind),
    .rd_cnt_o  (below_cnt)
  );

  jet_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && grp.num != 3'd0),
    .grp_i   (grp),
    .space_o (space),
    .evt_o   (evt_o)
  );

endmodule

/* design/jet_chk.sv */
// port-level checker for the json event tokenizer, bound to the top level
// depends on jet_pkg and json_event_tokenizer_core_defines.svh
`include "json_event_tokenizer_core_defines.svh"

module jet_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        evt_valid_i,
  input logic        evt_ready_i,
  input logic [3:0]  evt_kind_i,
  input logic [20:0] evt_amount_i,
  input logic [2:0]  evt_code_i,
  input logic        evt_last_i
);

  `JET_ASSERT_HOLD(a_evt_hold, evt_valid_i, evt_ready_i, "event dropped while stalled")
  `JET_ASSERT(a_code_only_err, (evt_valid_i && evt_kind_i != jet_pkg::EV_ERR) |-> (evt_code_i == 3'd0), "error code on non-error event")
  `JET_ASSERT(a_end_is_last, (evt_valid_i && (evt_kind_i == jet_pkg::EV_ERR || (evt_kind_i == jet_pkg::EV_DOC && evt_amount_i == 21'd0))) |-> evt_last_i, "event after document end")

endmodule

bind json_event_tokenizer_core jet_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .evt_valid_i  (evt_o.valid),
  .evt_ready_i  (evt_o.ready),
  .evt_kind_i   (evt_o.event_kind),
  .evt_amount_i (evt_o.amount),
  .evt_code_i   (evt_o.error_code),
  .evt_last_i   (evt_o.last_of_run)
);

/* dv/tb_json_event_tokenizer_core.sv */
// testbench for json_event_tokenizer_core: streams directed and random json text,
// predicts the event stream in place and checks every event transfer in order
// depends on jet_pkg, jet_in_if, jet_out_if and json_event_tokenizer_core
`timescale 1ns / 100ps

module tb_json_event_tokenizer_core;

  localparam int Depth    = 32;
  localparam int IdleMax  = 3000;
  localparam int ItemGoal = 450;

  typedef struct {
    jet_pkg::ev_kind_e kind;
    logic [19:0]       pos;
    logic [20:0]       amount;
    logic [2:0]        code;
    logic              last;
  } event_t;

  logic clk_i;
  logic rst_ni;

  jet_in_if  byte_if ();
  jet_out_if evt_if ();

  json_event_tokenizer_core #(
    .NEST_DEPTH (Depth),
    .OFFSET_BITS(20)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_if),
    .evt_o (evt_if)
  );

  // parser mirror
  jet_pkg::phase_e ph;
  bit              kind_stk [Depth];
  logic [19:0]     count_stk[Depth];
  int              lvl;
  logic [19:0]     offs;
  logic [19:0]     tok;
  bit              bslash;
  int              lit;
  bit              done;

  event_t step_q[$];
  event_t pending_events[$];

  int fail_cnt;
  int sent_bytes;
  int idle_pct;
  int stall_pct;
  int hold_cycles;
  int quiet_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void put_event(jet_pkg::ev_kind_e k, logic [19:0] p, logic [20:0] a,
                                    logic [2:0] e);
    event_t ev;
    if (step_q.size() < jet_pkg::MaxEvents) begin
      ev.kind = k;
      ev.pos = p;
      ev.amount = a;
      ev.code = e;
      ev.last = 1'b0;
      step_q.push_back(ev);
    end
  endfunction

  function automatic void raise_error(logic [19:0] o, jet_pkg::err_code_e e);
    put_event(jet_pkg::EV_ERR, o, '0, e);
    done = 1'b1;
  endfunction

  function automatic bit space_char(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int top_slot();
    int t;
    t = (lvl > 0) ? lvl - 1 : 0;
    return (t < Depth) ? t : Depth - 1;
  endfunction

  function automatic void value_done();
    if (lvl == 0) begin
      put_event(jet_pkg::EV_DOC, '0, '0, '0);
      done = 1'b1;
    end else begin
      ph = kind_stk[top_slot()] ? jet_pkg::PH_ARR_NEXT : jet_pkg::PH_OBJ_NEXT;
    end
  endfunction

  function automatic void close_level(logic [19:0] o);
    bit is_arr;
    is_arr = kind_stk[top_slot()];
    lvl--;
    put_event(is_arr ? jet_pkg::EV_ARR : jet_pkg::EV_OBJ, o, '0, '0);
    value_done();
  endfunction

  function automatic void open_level(logic [19:0] o, bit is_arr);
    if (lvl >= Depth) begin
      raise_error(o, jet_pkg::ERR_INVALID_VALUE);
      return;
    end
    kind_stk[lvl] = is_arr;
    count_stk[lvl] = '0;
    lvl++;
    put_event(is_arr ? jet_pkg::EV_ARR : jet_pkg::EV_OBJ, o, 21'd1, '0);
    ph = is_arr ? jet_pkg::PH_ARR_ELEM : jet_pkg::PH_OBJ_KEY;
  endfunction

  function automatic void begin_value(logic [7:0] c, logic [19:0] o);
    if (c == "{") open_level(o, 1'b0);
    else if (c == "[") open_level(o, 1'b1);
    else if (c == "\"") begin
      tok = o + 20'd1;
      bslash = 1'b0;
      ph = jet_pkg::PH_STR_TEXT;
    end else if (c == "t" || c == "f" || c == "n") begin
      lit = 1;
      ph = (c == "t") ? jet_pkg::PH_TRUE
         : ((c == "f") ? jet_pkg::PH_FALSE : jet_pkg::PH_NULL);
    end else if (digit_char(c) || c == "-") begin
      tok = o;
      ph = (c == "-") ? jet_pkg::PH_NUM_SIGN : jet_pkg::PH_NUM_INT;
    end else begin
      raise_error(o, jet_pkg::ERR_INVALID_VALUE);
    end
  endfunction

  function automatic void word_byte(logic [7:0] c, logic [19:0] o, string w,
                                    jet_pkg::ev_kind_e k, logic [20:0] a);
    if (lit < w.len() && c == w[lit]) begin
      lit++;
      if (lit == w.len()) begin
        lit = 0;
        put_event(k, '0, a, '0);
        value_done();
      end
    end else begin
      raise_error(o, jet_pkg::ERR_INVALID_VALUE);
    end
  endfunction

  // returns 1 on an unescaped closing quote
  function automatic bit quote_byte(logic [7:0] c, logic [19:0] o, jet_pkg::err_code_e e);
    if (c == 8'd0) begin
      raise_error(o, e);
      return 1'b0;
    end
    if (c == "\"" && !bslash) return 1'b1;
    bslash = (c == "\\");
    return 1'b0;
  endfunction

  function automatic void parse_char(logic [7:0] c, logic [19:0] o);
    int t;
    while (1) begin
      case (ph)
        jet_pkg::PH_VALUE: begin
          if (!space_char(c)) begin_value(c, o);
          return;
        end
        jet_pkg::PH_ARR_ELEM: begin
          if (space_char(c)) return;
          if (c == "]") begin
            close_level(o);
            return;
          end
          t = top_slot();
          put_event(jet_pkg::EV_IDX, o, {1'b0, count_stk[t]}, '0);
          count_stk[t] = count_stk[t] + 20'd1;
          begin_value(c, o);
          return;
        end
        jet_pkg::PH_ARR_NEXT: begin
          if (space_char(c)) return;
          if (c == ",") ph = jet_pkg::PH_ARR_ELEM;
          else if (c == "]") close_level(o);
          else raise_error(o, jet_pkg::ERR_UNTERM_ARR);
          return;
        end
        jet_pkg::PH_OBJ_KEY: begin
          if (space_char(c)) return;
          if (c == "}") close_level(o);
          else if (c == "\"") begin
            tok = o + 20'd1;
            bslash = 1'b0;
            ph = jet_pkg::PH_KEY_TEXT;
          end else raise_error(o, jet_pkg::ERR_MISSING_KEY);
          return;
        end
        jet_pkg::PH_KEY_TEXT: begin
          if (quote_byte(c, o, jet_pkg::ERR_UNTERM_KEY)) begin
            put_event(jet_pkg::EV_KEY, tok, {1'b0, o - tok}, '0);
            ph = jet_pkg::PH_OBJ_COLON;
          end
          return;
        end
        jet_pkg::PH_OBJ_COLON: begin
          if (space_char(c)) return;
          if (c == ":") ph = jet_pkg::PH_VALUE;
          else raise_error(o, jet_pkg::ERR_MISSING_VALUE);
          return;
        end
        jet_pkg::PH_OBJ_NEXT: begin
          if (space_char(c)) return;
          if (c == ",") ph = jet_pkg::PH_OBJ_KEY;
          else if (c == "}") close_level(o);
          else raise_error(o, jet_pkg::ERR_UNTERM_OBJ);
          return;
        end
        jet_pkg::PH_STR_TEXT: begin
          if (quote_byte(c, o, jet_pkg::ERR_UNTERM_STR)) begin
            put_event(jet_pkg::EV_STR, tok, {1'b0, o - tok}, '0);
            value_done();
          end
          return;
        end
        jet_pkg::PH_TRUE: begin
          word_byte(c, o, "true", jet_pkg::EV_BOOL, 21'd1);
          return;
        end
        jet_pkg::PH_FALSE: begin
          word_byte(c, o, "false", jet_pkg::EV_BOOL, 21'd0);
          return;
        end
        jet_pkg::PH_NULL: begin
          word_byte(c, o, "null", jet_pkg::EV_NULL, 21'd0);
          return;
        end
        jet_pkg::PH_NUM_SIGN, jet_pkg::PH_NUM_FRAC0, jet_pkg::PH_NUM_EXPSIGN: begin
          if (digit_char(c))
            ph = (ph == jet_pkg::PH_NUM_SIGN) ? jet_pkg::PH_NUM_INT
               : ((ph == jet_pkg::PH_NUM_FRAC0) ? jet_pkg::PH_NUM_FRAC
                                                : jet_pkg::PH_NUM_EXP);
          else raise_error(o, jet_pkg::ERR_INVALID_VALUE);
          return;
        end
        jet_pkg::PH_NUM_EXP0: begin
          if (c == "+" || c == "-") ph = jet_pkg::PH_NUM_EXPSIGN;
          else if (digit_char(c)) ph = jet_pkg::PH_NUM_EXP;
          else raise_error(o, jet_pkg::ERR_INVALID_VALUE);
          return;
        end
        jet_pkg::PH_NUM_INT, jet_pkg::PH_NUM_FRAC, jet_pkg::PH_NUM_EXP: begin
          if (digit_char(c)) return;
          if (c == "." && ph == jet_pkg::PH_NUM_INT) begin
            ph = jet_pkg::PH_NUM_FRAC0;
            return;
          end
          if ((c == "e" || c == "E") && ph != jet_pkg::PH_NUM_EXP) begin
            ph = jet_pkg::PH_NUM_EXP0;
            return;
          end
          // number ends, the byte is parsed again after the value
          put_event(jet_pkg::EV_NUM, tok, {1'b0, o - tok}, '0);
          value_done();
          if (done) return;
        end
        default: begin
          raise_error(o, jet_pkg::ERR_INVALID_VALUE);
          return;
        end
      endcase
    end
  endfunction

  function automatic void predict_events(logic [7:0] c, bit first, bit last);
    step_q.delete();
    if (first) begin
      ph = jet_pkg::PH_VALUE;
      lvl = 0;
      offs = '0;
      tok = '0;
      bslash = 1'b0;
      lit = 0;
      done = 1'b0;
      put_event(jet_pkg::EV_DOC, '0, 21'd1, '0);
    end
    if (!done) parse_char(c, offs);
    if (last && !done && c != 8'd0) parse_char(8'd0, offs + 20'd1);
    offs = offs + 20'd1;
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) pending_events.push_back(step_q[i]);
  endfunction

  // event checker
  always @(posedge clk_i) begin
    event_t ev;
    if (rst_ni && evt_if.valid && evt_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event kind %0d pos %0d", evt_if.event_kind, evt_if.position);
        fail_cnt++;
      end else begin
        ev = pending_events.pop_front();
        if (evt_if.event_kind !== ev.kind) begin
          $error("event_kind exp %0d got %0d", ev.kind, evt_if.event_kind);
          fail_cnt++;
        end
        if (evt_if.position !== ev.pos) begin
          $error("position exp %0d got %0d", ev.pos, evt_if.position);
          fail_cnt++;
        end
        if (evt_if.amount !== ev.amount) begin
          $error("amount exp %0d got %0d", ev.amount, evt_if.amount);
          fail_cnt++;
        end
        if (evt_if.error_code !== ev.code) begin
          $error("error_code exp %0d got %0d", ev.code, evt_if.error_code);
          fail_cnt++;
        end
        if (evt_if.last_of_run !== ev.last) begin
          $error("last_of_run exp %0d got %0d", ev.last, evt_if.last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  // event sink ready, with long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      evt_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      evt_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (evt_if.valid && evt_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleMax) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, bit first, bit last);
    if ($urandom_range(99) < idle_pct) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= c;
    byte_if.first_byte <= first;
    byte_if.last_byte <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    predict_events(c, first, last);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit first, bit last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], first && i == 0, last && i == s.len() - 1);
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    while (pending_events.size() > 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void add_space(ref logic [7:0] q[$]);
    if ($urandom_range(3) == 0) q.push_back($urandom_range(1) ? 8'd32 : 8'd10);
  endfunction

  function automatic void gen_value(ref logic [7:0] q[$], input int depth);
    int sel;
    int n;
    string w;
    sel = (depth > 4) ? $urandom_range(2, 7) : $urandom_range(0, 7);
    add_space(q);
    case (sel)
      0, 1: begin
        n = $urandom_range(0, 3);
        q.push_back(sel == 0 ? 8'h7b : 8'h5b);
        for (int i = 0; i < n; i++) begin
          if (sel == 0) begin
            q.push_back(8'h22);
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(97, 122)));
            q.push_back(8'h22);
            add_space(q);
            q.push_back(8'h3a);
          end
          gen_value(q, depth + 1);
          add_space(q);
          if (i < n - 1 || $urandom_range(4) == 0) q.push_back(8'h2c);
        end
        add_space(q);
        q.push_back(sel == 0 ? 8'h7d : 8'h5d);
      end
      2, 3: begin
        q.push_back(8'h22);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(5) == 0) begin
            q.push_back(8'h5c);
            q.push_back(8'h22);
          end else q.push_back(8'($urandom_range(35, 91)));
        end
        q.push_back(8'h22);
      end
      4: begin
        n = $urandom_range(2);
        w = (n == 0) ? "true" : ((n == 1) ? "false" : "null");
        for (int i = 0; i < w.len(); i++) q.push_back(w[i]);
      end
      default: begin
        if ($urandom_range(1)) q.push_back(8'h2d);
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(48, 57)));
        if ($urandom_range(1)) begin
          q.push_back(8'h2e);
          repeat ($urandom_range(1, 2)) q.push_back(8'($urandom_range(48, 57)));
        end
        if ($urandom_range(2) == 0) begin
          q.push_back($urandom_range(1) ? 8'h65 : 8'h45);
          n = $urandom_range(2);
          if (n == 1) q.push_back(8'h2b);
          if (n == 2) q.push_back(8'h2d);
          q.push_back(8'($urandom_range(48, 57)));
        end
      end
    endcase
  endfunction

  task automatic send_random_doc();
    logic [7:0] doc[$];
    int mode;
    bit zero_end;
    gen_value(doc, 0);
    mode = $urandom_range(9);
    if (mode == 0) doc[$urandom_range(doc.size() - 1)] = 8'($urandom_range(255));
    if (mode == 1 && doc.size() > 1) doc = doc[0:$urandom_range(doc.size() - 2)];
    if (mode == 2) repeat ($urandom_range(1, 3)) doc.push_back(8'($urandom_range(255)));
    zero_end = ($urandom_range(5) == 0);
    if (zero_end) doc.push_back(8'd0);
    foreach (doc[i]) send_byte(doc[i], i == 0, !zero_end && i == doc.size() - 1);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    // bytes before the first flagged byte parse from reset with no document start, trailing bytes ignored
    send_text("[1]x", 1'b0, 1'b0);
    send_text("{\"\\\"\":-0E2,}", 1'b1, 1'b1);
    send_text("[t", 1'b1, 1'b1);
    send_text("[", 1'b1, 1'b1);
    send_byte(8'd0, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_text("007", 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_deep_nesting();
    for (int i = 0; i <= Depth; i++) send_byte(8'h5b, i == 0, 1'b0);
    send_text("{a", 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_random_docs(int idle, int stall, int goal);
    idle_pct = idle;
    stall_pct = stall;
    goal += sent_bytes;
    while (sent_bytes < goal) send_random_doc();
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    repeat (6) send_random_doc();
    drain();
  endtask

  task automatic test_noise();
    idle_pct = 20;
    stall_pct = 20;
    repeat (60) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                          $urandom_range(3) == 0);
    drain();
  endtask

  initial begin
    fail_cnt = 0;
    sent_bytes = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    ph = jet_pkg::PH_VALUE;
    lvl = 0;
    offs = '0;
    tok = '0;
    bslash = 1'b0;
    lit = 0;
    done = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.first_byte = 1'b0;
    byte_if.last_byte = 1'b0;
    evt_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_deep_nesting();
    test_random_docs(0, 0, ItemGoal / 6);
    test_random_docs(70, 0, ItemGoal / 6);
    test_random_docs(0, 70, ItemGoal / 6);
    test_random_docs(20, 20, ItemGoal / 6);
    test_backpressure();
    test_noise();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending_events.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/jet_pkg.sv
design/jet_if.sv
design/jet_parse.sv
design/jet_stack.sv
design/jet_evq.sv
design/json_event_tokenizer_core.sv
design/jet_chk.sv
dv/tb_json_event_tokenizer_core.sv
